// ===== sv/wbps_pkg.sv =====
// Shared constants, types and register codes for the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 64;
    localparam int OFFSET_OUT_W    = 32;
    localparam int MASK_W          = 16;
    localparam int LEN_W           = 5;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_BASE   = 3'd0,
        CFG_PATTERN_LOW  = 3'd1,
        CFG_PATTERN_HIGH = 3'd2,
        CFG_WILDCARD     = 3'd3,
        CFG_LENGTH       = 3'd4
    } cfg_index_t;

    // Status of the window stage as seen by the match stage
    typedef struct packed {
        logic valid;
        logic last;
    } wbps_s1_ctl_t;

endpackage

// ===== sv/wbps_if.sv =====
// Stream interfaces for image bytes in and scan results out.
interface byte_stream_if;
    import wbps_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] image_byte;
    logic              end_of_image;

    modport source (output valid, output image_byte, output end_of_image, input ready);
    modport sink   (input valid, input image_byte, input end_of_image, output ready);
endinterface

interface scan_result_if;
    import wbps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [ADDR_W-1:0]       match_address;
    logic [OFFSET_OUT_W-1:0] match_offset;

    modport source (output valid, output found, output match_address, output match_offset,
                    input ready);
    modport sink   (input valid, input found, input match_address, input match_offset,
                    output ready);
endinterface

// ===== sv/wbps_window.sv =====
// Input stage: shift window of recent image bytes and saturating byte count.
module wbps_window
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    byte_stream_if.sink                        byte_in,
    input  logic                               advance,
    output wbps_s1_ctl_t                       s1_ctl,
    output logic [PATTERN_MAX-1:0][BYTE_W-1:0] window,
    output logic [OFFSET_BITS-1:0]             count
);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_reg, window_next, base_window;
    logic [OFFSET_BITS-1:0]             count_reg, count_next, base_count;
    logic                               valid_reg, valid_next;
    logic                               last_reg, last_next;
    logic                               accept;

    assign byte_in.ready = !valid_reg || advance;
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        // start from a clean window after the end-of-image byte
        base_window = last_reg ? '0 : window_reg;
        base_count  = last_reg ? '0 : count_reg;
        window_next = window_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        valid_next  = advance ? 1'b0 : valid_reg;
        if (accept)
        begin
            window_next[0] = byte_in.image_byte;
            for (int i = 1; i < PATTERN_MAX; i++)
            begin
                window_next[i] = base_window[i-1];
            end
            count_next = (base_count == '1) ? base_count : base_count + OFFSET_BITS'(1);
            last_next  = byte_in.end_of_image;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
        end
    end

    assign s1_ctl.valid = valid_reg;
    assign s1_ctl.last  = last_reg;
    assign window       = window_reg;
    assign count        = count_reg;

endmodule

// ===== sv/wbps_match.sv =====
// Match stage: compare window against signature and register the result word.
module wbps_match
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  wbps_s1_ctl_t                       s1_ctl,
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window,
    input  logic [OFFSET_BITS-1:0]             count,
    input  logic [ADDR_W-1:0]                  image_base,
    input  logic [2*CFG_DATA_W-1:0]            pattern,
    input  logic [MASK_W-1:0]                  wildcard_mask,
    input  logic [LEN_W-1:0]                   pattern_length,
    output logic                               advance,
    scan_result_if.source                      result_out
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic                    reported_reg, reported_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [OFFSET_OUT_W-1:0] offset_reg;

    logic [LEN_W-1:0]        eff_len;
    logic [PATTERN_MAX-1:0]  pos_ok;
    logic [LEN_W-1:0]        pos_idx;
    logic                    hit, emit;
    logic [OFFSET_BITS-1:0]  off;
    logic                    can_load;

    assign can_load = !out_valid_reg || result_out.ready;
    assign advance  = s1_ctl.valid && can_load;

    always_comb
    begin
        pos_idx = '0;
        // clamp length into one to PATTERN_MAX
        priority if (pattern_length == '0)
            eff_len = LEN_W'(1);
        else if (pattern_length > LEN_W'(PATTERN_MAX))
            eff_len = LEN_W'(PATTERN_MAX);
        else
            eff_len = pattern_length;

        // signature byte k lines up with the byte taken eff_len-1-k words ago
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pos_idx   = eff_len - LEN_W'(1) - LEN_W'(k);
            pos_ok[k] = (LEN_W'(k) >= eff_len) || wildcard_mask[k] ||
                        (window[pos_idx[IDX_W-1:0]] == pattern[k*BYTE_W +: BYTE_W]);
        end

        off  = count - OFFSET_BITS'(eff_len);
        hit  = !reported_reg && (count >= OFFSET_BITS'(eff_len)) && (&pos_ok);
        emit = !reported_reg && (hit || s1_ctl.last);

        reported_next  = reported_reg;
        out_valid_next = result_out.ready ? 1'b0 : out_valid_reg;
        if (advance)
        begin
            reported_next  = s1_ctl.last ? 1'b0 : (reported_reg || hit);
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload until the next result word is loaded
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            found_reg  <= hit;
            addr_reg   <= hit ? image_base + ADDR_W'(off) : '0;
            offset_reg <= hit ? OFFSET_OUT_W'(off) : '0;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.found         = found_reg;
    assign result_out.match_address = addr_reg;
    assign result_out.match_offset  = offset_reg;

endmodule

// ===== sv/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner: window stage, match stage and registers.
// A result word passes the window register and then the result register before it is offered.
// Throughput: one image byte per cycle; window shift and parallel compare take one stage each.
// A result word left unread holds the byte behind it and stops the input until it is taken.
// Reset (rst_n, async, active low) clears the window, byte count, match flag and valid
// bits, sets pattern_length to one and the other configuration registers to zero.
module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    byte_stream_if.sink            byte_in,
    scan_result_if.source          result_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers; the user must write them only between scans, which the block does not enforce
    logic [ADDR_W-1:0]     image_base_reg,    image_base_next;
    logic [CFG_DATA_W-1:0] pattern_low_reg,   pattern_low_next;
    logic [CFG_DATA_W-1:0] pattern_high_reg,  pattern_high_next;
    logic [MASK_W-1:0]     wildcard_mask_reg, wildcard_mask_next;
    logic [LEN_W-1:0]      length_reg,        length_next;

    // Between the window stage and the match stage
    wbps_s1_ctl_t                       s1_ctl;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] window;
    logic [OFFSET_BITS-1:0]             count;
    logic                               advance;

    // Decode a write; indexes beyond the register list drop silently
    always_comb
    begin
        image_base_next    = image_base_reg;
        pattern_low_next   = pattern_low_reg;
        pattern_high_next  = pattern_high_reg;
        wildcard_mask_next = wildcard_mask_reg;
        length_next        = length_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_BASE:   image_base_next    = cfg_data;
                CFG_PATTERN_LOW:  pattern_low_next   = cfg_data;
                CFG_PATTERN_HIGH: pattern_high_next  = cfg_data;
                CFG_WILDCARD:     wildcard_mask_next = cfg_data[MASK_W-1:0];
                CFG_LENGTH:       length_next        = cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_base_reg    <= '0;
            pattern_low_reg   <= '0;
            pattern_high_reg  <= '0;
            wildcard_mask_reg <= '0;
            length_reg        <= LEN_W'(1);
        end
        else
        begin
            image_base_reg    <= image_base_next;
            pattern_low_reg   <= pattern_low_next;
            pattern_high_reg  <= pattern_high_next;
            wildcard_mask_reg <= wildcard_mask_next;
            length_reg        <= length_next;
        end
    end

    // Stage one: shift each accepted word into the window, advance the count,
    // rearm on the word after end of image
    wbps_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .advance (advance),
        .s1_ctl  (s1_ctl),
        .window  (window),
        .count   (count)
    );

    // Stage two: compare against the signature, track the first match of the
    // scan and load the result register; it stalls only when that register is full
    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_ctl         (s1_ctl),
        .window         (window),
        .count          (count),
        .image_base     (image_base_reg),
        .pattern        ({pattern_high_reg, pattern_low_reg}),
        .wildcard_mask  (wildcard_mask_reg),
        .pattern_length (length_reg),
        .advance        (advance),
        .result_out     (result_out)
    );

endmodule

// ===== tb/tb_wildcard_byte_pattern_scan.sv =====
// Self-checking testbench for the wildcard byte pattern scanner, with a scan predictor.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scan
    import wbps_pkg::*;
();

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 11;
    localparam int          WINDOW_DEPTH    = 16;
    localparam int          SIG_MAX         = PATTERN_MAX_DEF;
    // A result passes the window and match stage registers after the completing byte; leave a settling margin
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          RANDOM_ITEMS    = 450;
    localparam int          LONG_HOLD       = 80;
    localparam int          MISMATCH_SHOWN  = 10;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    // One index past the register list; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_BEYOND_LIST = CFG_LENGTH + 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] image_byte;
        logic              end_of_image;
    } image_word_t;

    typedef struct packed {
        logic                    found;
        logic [ADDR_W-1:0]       match_address;
        logic [OFFSET_OUT_W-1:0] match_offset;
    } scan_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    byte_stream_if byte_bus ();
    scan_result_if result_bus ();

    wildcard_byte_pattern_scan u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_bus.sink),
        .result_out (result_bus.source),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Predictor copy of the registers, reset values included
    logic [ADDR_W-1:0]  base_q     = '0;
    logic [63:0]        sig_low_q  = '0;
    logic [63:0]        sig_high_q = '0;
    logic [MASK_W-1:0]  wild_q     = '0;
    logic [LEN_W-1:0]   length_q   = LEN_W'(1);

    // Predictor copy of the scan state
    logic [BYTE_W-1:0]          scan_window [WINDOW_DEPTH] = '{default: '0};
    logic [OFFSET_BITS_DEF-1:0] bytes_counted = '0;
    logic                       hit_reported  = 1'b0;

    image_word_t  pending_bytes [$];
    scan_result_t due_results   [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          bytes_queued   = 0;
    int unsigned cycle_count    = 0;

    // Long receiver hold-off: toggle hold_req to start one
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    image_word_t send_word;
    scan_result_t got_word;
    scan_result_t want_word;

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------

    // Clamp the length register into 1..SIG_MAX, as the block does
    function automatic int unsigned applied_length();
        int unsigned n;
        n = length_q;
        if (n == 0)
            n = 1;
        if (n > SIG_MAX)
            n = SIG_MAX;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] sig_byte(input int unsigned k);
        logic [127:0] sig_all;
        sig_all = {sig_high_q, sig_low_q};
        return sig_all[8*k +: 8];
    endfunction

    // Advance the predicted scan by one accepted byte; queue the result it causes
    function automatic void track_image_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        int unsigned  len_used;
        int unsigned  k;
        logic         hit;
        logic [OFFSET_BITS_DEF-1:0] start_off;
        scan_result_t r;
        len_used = applied_length();
        for (k = WINDOW_DEPTH - 1; k > 0; k--)
            scan_window[k] = scan_window[k-1];
        scan_window[0] = b;
        // Saturate rather than wrap
        if (bytes_counted != '1)
            bytes_counted++;

        if (!hit_reported && bytes_counted >= len_used)
        begin
            hit = 1'b1;
            // Signature byte k sits len_used-1-k places back from the newest byte
            for (k = 0; k < len_used; k++)
                if (!wild_q[k] && scan_window[len_used-1-k] != sig_byte(k))
                    hit = 1'b0;
            if (hit)
            begin
                start_off       = bytes_counted - len_used;
                r.found         = 1'b1;
                r.match_address = base_q + ADDR_W'(start_off);
                r.match_offset  = OFFSET_OUT_W'(start_off);
                due_results.insert(due_results.size(), r);
                hit_reported    = 1'b1;
            end
        end

        // End of image: report a miss if nothing matched, then rearm
        if (eoi)
        begin
            if (!hit_reported)
            begin
                r = '0;
                due_results.insert(due_results.size(), r);
            end
            scan_window   = '{default: '0};
            bytes_counted = '0;
            hit_reported  = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offer the next queued word, hold it until taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_bus.valid        <= 1'b0;
            byte_bus.image_byte   <= '0;
            byte_bus.end_of_image <= 1'b0;
        end
        else
        begin
            if (byte_bus.valid && byte_bus.ready)
                track_image_byte(byte_bus.image_byte, byte_bus.end_of_image);
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    send_word = pending_bytes.pop_front();
                    byte_bus.valid        <= 1'b1;
                    byte_bus.image_byte   <= send_word.image_byte;
                    byte_bus.end_of_image <= send_word.end_of_image;
                end
                else
                    byte_bus.valid <= 1'b0;
            end
        end
    end

    // Count down a long receiver hold-off in its own process
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result receiver: stall at random, and for the whole of a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result monitor: compare every taken word with the oldest prediction
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
            $display("[%0t] %s: expected found=%0b addr=%h off=%h, got found=%0b addr=%h off=%h",
                     $realtime, what, want_word.found, want_word.match_address,
                     want_word.match_offset, got_word.found, got_word.match_address,
                     got_word.match_offset);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got_word.found         = result_bus.found;
            got_word.match_address = result_bus.match_address;
            got_word.match_offset  = result_bus.match_offset;
            if (due_results.size() == 0)
            begin
                want_word = '0;
                note_mismatch("result with nothing expected");
            end
            else
            begin
                want_word = due_results.pop_front();
                if (got_word.found !== want_word.found)
                    note_mismatch("found differs");
                else if (got_word.match_address !== want_word.match_address)
                    note_mismatch("match_address differs");
                else if (got_word.match_offset !== want_word.match_offset)
                    note_mismatch("match_offset differs");
            end
        end
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register and mirror it in the predictor; only while idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_IMAGE_BASE:   base_q     = data;
            CFG_PATTERN_LOW:  sig_low_q  = data;
            CFG_PATTERN_HIGH: sig_high_q = data;
            CFG_WILDCARD:     wild_q     = data[MASK_W-1:0];
            CFG_LENGTH:       length_q   = data[LEN_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        image_word_t w;
        w.image_byte   = b;
        w.end_of_image = eoi;
        pending_bytes.insert(pending_bytes.size(), w);
        bytes_queued++;
    endtask

    // Queue one image; noise leans on signature bytes so near misses are common.
    // With plant set, drop a full signature copy somewhere that fits.
    task automatic queue_scan(input int unsigned n, input bit plant);
        int unsigned       len_used;
        int unsigned       start;
        int unsigned       k;
        logic [BYTE_W-1:0] img [$];
        len_used = applied_length();
        for (k = 0; k < n; k++)
            img.insert(img.size(), $urandom_range(0, 1) ? BYTE_W'($urandom)
                                   : sig_byte($urandom_range(0, len_used - 1)));
        if (plant && n >= len_used)
        begin
            start = $urandom_range(0, n - len_used);
            for (k = 0; k < len_used; k++)
                if (!wild_q[k])
                    img[start + k] = sig_byte(k);
        end
        for (k = 0; k < n; k++)
            push_byte(img[k], k == n - 1);
    endtask

    // Pause the sender until every predicted result has come, then let the pipe settle
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || byte_bus.valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Reset and stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int phase;
        int unsigned k;
        logic [MASK_W-1:0] mask_pick;
        logic [LEN_W-1:0]  len_pick;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // Reset defaults: length one, zero signature, so a lone zero byte matches
        push_byte(8'h00, 1'b1);
        wait_until_drained();

        // Length zero acts as one; all-ones base wraps the address to zero
        write_reg(CFG_IMAGE_BASE, '1);
        write_reg(CFG_PATTERN_LOW, '1);
        write_reg(CFG_LENGTH, '0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_until_drained();

        // Short image: even an all-wildcard signature cannot complete in two bytes
        write_reg(CFG_LENGTH, CFG_DATA_W'(3));
        write_reg(CFG_WILDCARD, CFG_DATA_W'(16'hFFFF));
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b1);
        wait_until_drained();

        // After a match, later hits in the same image are dropped
        write_reg(CFG_IMAGE_BASE, CFG_DATA_W'(64'h1000));
        write_reg(CFG_LENGTH, CFG_DATA_W'(1));
        write_reg(CFG_WILDCARD, '0);
        write_reg(CFG_PATTERN_LOW, CFG_DATA_W'(64'hAB));
        push_byte(8'hAB, 1'b0);
        push_byte(8'hAB, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_until_drained();

        // Register change in the middle of an image applies to the next byte
        write_reg(CFG_LENGTH, CFG_DATA_W'(2));
        write_reg(CFG_PATTERN_LOW, CFG_DATA_W'(64'hA55A));
        push_byte(8'h5A, 1'b0);
        wait_until_drained();
        write_reg(CFG_WILDCARD, CFG_DATA_W'(16'h0002));
        push_byte(8'h77, 1'b1);
        wait_until_drained();

        // Oversized length clamps to sixteen; full-width match completes on the last byte.
        // A write past the register list goes in first and must be ignored.
        write_reg(CFG_BEYOND_LIST, '1);
        write_reg(CFG_IMAGE_BASE, CFG_DATA_W'(64'h8000_0000_0000_0000));
        write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
        write_reg(CFG_LENGTH, CFG_DATA_W'(31));
        write_reg(CFG_WILDCARD, CFG_DATA_W'(16'hFFFF));
        for (k = 0; k < WINDOW_DEPTH; k++)
            push_byte(BYTE_W'($urandom), k == WINDOW_DEPTH - 1);
        wait_until_drained();

        // Random phases: new setting each time, then a batch of images
        bytes_queued = 0;
        phase        = 0;
        while (bytes_queued < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase

            case ($urandom_range(0, 3))
                0:       write_reg(CFG_IMAGE_BASE, '0);
                1:       write_reg(CFG_IMAGE_BASE, '1);
                default: write_reg(CFG_IMAGE_BASE, {$urandom, $urandom});
            endcase
            write_reg(CFG_PATTERN_LOW, {$urandom, $urandom});
            write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
            case ($urandom_range(0, 4))
                0:       mask_pick = '0;
                1:       mask_pick = '1;
                2:       mask_pick = MASK_W'($urandom & $urandom);
                default: mask_pick = MASK_W'($urandom);
            endcase
            // Upper data bits are random; only the low sixteen should land
            write_reg(CFG_WILDCARD, {32'($urandom), 16'($urandom), mask_pick});
            case ($urandom_range(0, 9))
                0:       len_pick = '0;
                1:       len_pick = '1;
                2:       len_pick = LEN_W'(SIG_MAX);
                3:       len_pick = LEN_W'($urandom_range(SIG_MAX + 1, 30));
                4, 5, 6: len_pick = LEN_W'($urandom_range(1, 4));
                default: len_pick = LEN_W'($urandom_range(1, SIG_MAX));
            endcase
            write_reg(CFG_LENGTH, {59'($urandom), len_pick});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_BEYOND_LIST, {$urandom, $urandom});
            @(negedge clk);

            if (phase == 3)
            begin
                // Hold the receiver off while the sender keeps offering short images,
                // so the block fills and pushes back on its input
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_req       = ~hold_req;
                repeat (12) queue_scan($urandom_range(1, 4), 1'b1);
            end
            else
            begin
                // Mostly short images; now and then a long one
                repeat ($urandom_range(3, 6))
                    queue_scan(($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, applied_length() + 10),
                               $urandom_range(0, 3) != 0);
            end
            wait_until_drained();
            phase++;
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
